[sv/bts_pkg.sv]
// package for the bilinear texture sampler
// types, codes and constants shared by the controller, datapath and top level
package bts_pkg;

    typedef struct packed {
        logic               opcode;
        logic [11:0]        texel_index;
        logic [7:0]         texel_red;
        logic [7:0]         texel_green;
        logic [7:0]         texel_blue;
        logic signed [15:0] coord_u;
        logic signed [15:0] coord_v;
    } bts_in_t;

    typedef struct packed {
        logic [7:0] sample_red;
        logic [7:0] sample_green;
        logic [7:0] sample_blue;
    } bts_out_t;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic REG_TEX_WIDTH  = 1'b0;
    localparam logic REG_TEX_HEIGHT = 1'b1;

    localparam logic [6:0] SIZE_RESET = 7'd64;
    localparam logic [6:0] SIZE_MIN   = 7'd2;
    localparam logic [6:0] SIZE_MAX   = 7'd64;

    localparam logic signed [23:0] HALF_TEXEL = 24'sd2048;
    localparam logic [3:0]         FOLD_STEPS = 4'd10;

    localparam logic [2:0] FETCH_LAST = 3'd4;
    localparam logic [1:0] CHAN_LAST  = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       write_tex;
        logic       scale;
        logic       fold_start;
        logic       fetch_issue;
        logic [1:0] fetch_sel;
        logic       texel_capture;
        logic [1:0] capture_sel;
        logic       blend_row;
        logic       blend_col;
        logic [1:0] chan_sel;
        logic       out_load;
    } bts_cmd_t;

    typedef struct packed {
        logic fold_done;
    } bts_status_t;

    function automatic logic [7:0] chan_of(input logic [23:0] texel, input logic [1:0] k);
        logic [7:0] c;
        case (k)
            2'd0:    c = texel[23:16];
            2'd1:    c = texel[15:8];
            default: c = texel[7:0];
        endcase
        return c;
    endfunction

endpackage

[sv/bts_fold.sv]
// index folder: maps a signed texel index into 0..d with a ten-step remainder
// depends on bts_pkg
module bts_fold
    import bts_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [10:0] idx,
    input  logic [5:0]         dmax,
    output logic               done,
    output logic [5:0]         folded
);

    typedef enum logic [1:0] {
        MODE_KEEP = 2'd0,
        MODE_NEG  = 2'd1,
        MODE_BIG  = 2'd2
    } mode_t;

    mode_t      mode_reg;
    logic [9:0] a_reg;
    logic [5:0] rem_reg;
    logic [5:0] d_reg;
    logic [5:0] keep_reg;
    logic [3:0] cnt_reg;
    logic [6:0] trial;

    assign trial = {rem_reg, a_reg[9]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= FOLD_STEPS;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg    <= dmax;
            keep_reg <= idx[5:0];
            rem_reg  <= '0;
            if (idx < 0) begin
                mode_reg <= MODE_NEG;
                a_reg    <= 10'(-idx);
            end else if (idx > $signed({5'b0, dmax})) begin
                mode_reg <= MODE_BIG;
                a_reg    <= 10'(idx - 11'sd1);
            end else begin
                mode_reg <= MODE_KEEP;
                a_reg    <= 10'(idx);
            end
        end else if (cnt_reg != '0) begin
            a_reg <= {a_reg[8:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                rem_reg <= 6'(trial - {1'b0, d_reg});
            end else begin
                rem_reg <= trial[5:0];
            end
        end
    end

    always_comb begin
        case (mode_reg)
            MODE_NEG: folded = (rem_reg == '0) ? 6'd0 : d_reg - rem_reg;
            MODE_BIG: folded = rem_reg + 6'd1;
            default:  folded = keep_reg;
        endcase
    end

    assign done = (cnt_reg == '0);

endmodule

[sv/bts_datapath.sv]
// datapath: size registers, texture memory, scaling, folding, fetch and blend
// depends on bts_pkg and bts_fold
module bts_datapath
    import bts_pkg::*;
#(
    parameter int MAX_TEXELS = 4096
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  bts_cmd_t    cmd,
    output bts_status_t status,
    input  bts_in_t     s_data,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    output bts_out_t    m_data
);

    localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int IW = (AW > 13) ? AW : 13;

    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [6:0]  w_eff;
    logic [6:0]  h_eff;

    bts_in_t     in_reg;
    logic signed [23:0] pu_reg;
    logic signed [23:0] pv_reg;
    logic signed [23:0] prod_u;
    logic signed [23:0] prod_v;

    logic signed [10:0] xl;
    logic signed [10:0] xr;
    logic signed [10:0] yd;
    logic signed [10:0] yu;
    logic [11:0] s_w;
    logic [11:0] t_w;
    logic [5:0]  xl_f;
    logic [5:0]  xr_f;
    logic [5:0]  yd_f;
    logic [5:0]  yu_f;
    logic [3:0]  fdone;

    logic [23:0] mem [MAX_TEXELS];
    logic [23:0] rd_reg;
    logic        rd_zero_reg;
    logic [23:0] texel_reg [4];
    logic [5:0]  row_sel;
    logic [5:0]  col_sel;
    logic [12:0] tex_addr;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic        rd_in_range;
    logic        wr_in_range;

    logic [19:0] lo_reg;
    logic [19:0] hi_reg;
    logic [7:0]  res_reg [3];
    bts_out_t    out_reg;

    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
    logic [7:0]  c3;
    logic signed [21:0] lo_prod;
    logic signed [21:0] hi_prod;
    logic signed [21:0] lo_next;
    logic signed [21:0] hi_next;
    logic signed [20:0] col_diff;
    logic signed [33:0] col_prod;
    logic signed [33:0] mix;

    // size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_TEX_WIDTH:  width_reg  <= cfg_data;
                REG_TEX_HEIGHT: height_reg <= cfg_data;
                default:        width_reg  <= width_reg;
            endcase
        end
    end

    assign w_eff = (width_reg < SIZE_MIN) ? SIZE_MIN :
                   (width_reg > SIZE_MAX) ? SIZE_MAX : width_reg;
    assign h_eff = (height_reg < SIZE_MIN) ? SIZE_MIN :
                   (height_reg > SIZE_MAX) ? SIZE_MAX : height_reg;

    // scaling
    assign prod_u = in_reg.coord_u * $signed({1'b0, w_eff});
    assign prod_v = in_reg.coord_v * $signed({1'b0, h_eff});

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.scale) begin
            pu_reg <= prod_u - HALF_TEXEL;
            pv_reg <= prod_v - HALF_TEXEL;
        end
    end

    assign xl  = pu_reg[22:12];
    assign yd  = pv_reg[22:12];
    assign s_w = pu_reg[11:0];
    assign t_w = pv_reg[11:0];
    assign xr  = xl + 11'(s_w != '0);
    assign yu  = yd + 11'(t_w != '0);

    bts_fold u_fold_xl (.aclk, .aresetn, .start(cmd.fold_start), .idx(xl),
                        .dmax(6'(w_eff - 7'd1)), .done(fdone[0]), .folded(xl_f));
    bts_fold u_fold_xr (.aclk, .aresetn, .start(cmd.fold_start), .idx(xr),
                        .dmax(6'(w_eff - 7'd1)), .done(fdone[1]), .folded(xr_f));
    bts_fold u_fold_yd (.aclk, .aresetn, .start(cmd.fold_start), .idx(yd),
                        .dmax(6'(h_eff - 7'd1)), .done(fdone[2]), .folded(yd_f));
    bts_fold u_fold_yu (.aclk, .aresetn, .start(cmd.fold_start), .idx(yu),
                        .dmax(6'(h_eff - 7'd1)), .done(fdone[3]), .folded(yu_f));

    assign status.fold_done = &fdone;

    // texture memory, single port
    assign row_sel     = cmd.fetch_sel[1] ? yu_f : yd_f;
    assign col_sel     = cmd.fetch_sel[0] ? xr_f : xl_f;
    assign tex_addr    = 13'(row_sel) * 13'(w_eff) + 13'(col_sel);
    assign rd_addr     = IW'(tex_addr);
    assign wr_addr     = IW'(s_data.texel_index);
    assign rd_in_range = 32'(tex_addr) < MAX_TEXELS;
    assign wr_in_range = 32'(s_data.texel_index) < MAX_TEXELS;

    always_ff @(posedge aclk) begin
        if (cmd.write_tex && wr_in_range) begin
            mem[wr_addr[AW-1:0]] <= {s_data.texel_red, s_data.texel_green,
                                     s_data.texel_blue};
        end
        if (cmd.fetch_issue) begin
            rd_reg      <= mem[rd_addr[AW-1:0]];
            rd_zero_reg <= !rd_in_range;
        end
        if (cmd.texel_capture) begin
            texel_reg[cmd.capture_sel] <= rd_zero_reg ? 24'd0 : rd_reg;
        end
    end

    // blend, one channel at a time
    assign c0 = chan_of(texel_reg[0], cmd.chan_sel);
    assign c1 = chan_of(texel_reg[1], cmd.chan_sel);
    assign c2 = chan_of(texel_reg[2], cmd.chan_sel);
    assign c3 = chan_of(texel_reg[3], cmd.chan_sel);

    assign lo_prod = ($signed({1'b0, c1}) - $signed({1'b0, c0})) * $signed({1'b0, s_w});
    assign hi_prod = ($signed({1'b0, c3}) - $signed({1'b0, c2})) * $signed({1'b0, s_w});
    assign lo_next = $signed({2'b0, c0, 12'b0}) + lo_prod;
    assign hi_next = $signed({2'b0, c2, 12'b0}) + hi_prod;

    assign col_diff = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
    assign col_prod = col_diff * $signed({1'b0, t_w});
    assign mix      = $signed({2'b0, lo_reg, 12'b0}) + col_prod + 34'sh800000;

    always_ff @(posedge aclk) begin
        if (cmd.blend_row) begin
            lo_reg <= lo_next[19:0];
            hi_reg <= hi_next[19:0];
        end
        if (cmd.blend_col) begin
            res_reg[cmd.chan_sel] <= mix[31:24];
        end
        if (cmd.out_load) begin
            out_reg.sample_red   <= res_reg[0];
            out_reg.sample_green <= res_reg[1];
            out_reg.sample_blue  <= res_reg[2];
        end
    end

    assign m_data = out_reg;

endmodule

[sv/bts_ctrl.sv]
// controller state machine: sequences scale, fold, fetch, blend and output
// depends on bts_pkg
module bts_ctrl
    import bts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    output logic        m_valid,
    input  logic        m_ready,
    output bts_cmd_t    cmd,
    input  bts_status_t status
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCALE = 7'b0000010,
        ST_START = 7'b0000100,
        ST_FOLD  = 7'b0001000,
        ST_FETCH = 7'b0010000,
        ST_ROW   = 7'b0100000,
        ST_COL   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] fetch_reg, fetch_next;
    logic [1:0] chan_reg, chan_next;
    logic       m_valid_reg;
    logic       emit_pend_reg, emit_pend_next;
    logic       accept;
    logic       out_free;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        fetch_next     = fetch_reg;
        chan_next      = chan_reg;
        emit_pend_next = emit_pend_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        cmd.fetch_sel  = fetch_reg[1:0];
        cmd.capture_sel = 2'(fetch_reg - 3'd1);
        cmd.chan_sel   = chan_reg;
        unique case (state_reg)
            ST_IDLE: begin
                // result waiting for a free output register
                if (emit_pend_reg) begin
                    if (out_free) begin
                        cmd.out_load   = 1'b1;
                        emit_pend_next = 1'b0;
                    end
                end else begin
                    s_ready       = 1'b1;
                    cmd.capture   = accept;
                    cmd.write_tex = accept && (s_opcode == OP_LOAD);
                    if (accept && (s_opcode == OP_SAMPLE)) begin
                        state_next = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                cmd.scale  = 1'b1;
                state_next = ST_START;
            end
            ST_START: begin
                cmd.fold_start = 1'b1;
                state_next     = ST_FOLD;
            end
            ST_FOLD: begin
                if (status.fold_done) begin
                    fetch_next = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch_issue   = (fetch_reg != FETCH_LAST);
                cmd.texel_capture = (fetch_reg != '0);
                fetch_next        = fetch_reg + 3'd1;
                if (fetch_reg == FETCH_LAST) begin
                    chan_next  = '0;
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                cmd.blend_row = 1'b1;
                state_next    = ST_COL;
            end
            ST_COL: begin
                cmd.blend_col = 1'b1;
                if (chan_reg == CHAN_LAST) begin
                    emit_pend_next = 1'b1;
                    state_next     = ST_IDLE;
                end else begin
                    chan_next  = chan_reg + 2'd1;
                    state_next = ST_ROW;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fetch_reg     <= '0;
            chan_reg      <= '0;
            emit_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fetch_reg     <= fetch_next;
            chan_reg      <= chan_next;
            emit_pend_reg <= emit_pend_next;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

endmodule

[sv/bilinear_texture_sampler.sv]
// Bilinear texture sampler. A load transfer writes one RGB texel. A sample
// transfer holds off all further input until its result is loaded into the
// output register: the ten-step remainder units fold the four neighbour
// indices, then come four reads of the single-port texture memory and a row
// and column blend per channel. The result sits in an output register, so loads
// and the next sample are taken while it waits. Unwritten texels read undefined.
// depends on bts_pkg, bts_ctrl, bts_datapath, bts_fold
module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_TEXELS = 4096
)
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  bts_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output bts_out_t   m_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    bts_cmd_t    cmd;
    bts_status_t status;

    assign cfg_ready = 1'b1;

    bts_ctrl u_ctrl (
        .aclk,
        .aresetn,
        .s_valid,
        .s_ready,
        .s_opcode (s_data.opcode),
        .m_valid,
        .m_ready,
        .cmd,
        .status
    );

    bts_datapath #(.MAX_TEXELS(MAX_TEXELS)) u_datapath (
        .aclk,
        .aresetn,
        .cmd,
        .status,
        .s_data,
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index,
        .cfg_data,
        .m_data
    );

endmodule

[sv/bts_checker.sv]
// port checker for the bilinear texture sampler, bound to the top level
// depends on bts_pkg
module bts_checker
    import bts_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input bts_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input bts_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("stalled result changed");

    a_busy_after_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_SAMPLE) |=> !s_ready)
        else $error("input taken while sample in progress");

    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_SAMPLE) |=> ##1 !$rose(m_valid))
        else $error("result too early after sample");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (
    .aclk,
    .aresetn,
    .s_valid,
    .s_ready,
    .s_data,
    .m_valid,
    .m_ready,
    .m_data
);
